### src/sobel_gradient_magnitude_core_macros.svh
// Assertion macros shared by the checker of the Sobel gradient magnitude core.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef SOBEL_GRADIENT_MAGNITUDE_CORE_MACROS_SVH
`define SOBEL_GRADIENT_MAGNITUDE_CORE_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define SGM_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("sgm assertion failed");

// Next-cycle implication, checked outside of reset.
`define SGM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sgm assertion failed");

`endif

### src/sgm_pkg.sv
// Shared types and constants of the Sobel gradient magnitude core.
// Used by the controller, the datapath and the top level.
package sgm_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam int RESET_WIDTH   = 640;
  localparam int RESET_HEIGHT  = 480;
  localparam int PIX_W         = 8;
  localparam int CFG_W         = 13;
  localparam int CFG_IDX_W     = 1;
  localparam int ROW_W         = 12;
  localparam int COL_W         = 12;
  localparam int MAG_W         = 11;
  localparam int GRAD_W        = 11;
  localparam int SUM_W         = 21;
  localparam int OUT_DATA_W    = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic rd;
    logic step;
    logic sq_x;
    logic sq_y;
    logic root;
    logic load_out;
  } sgm_cmd_t;

  typedef struct packed {
    logic interior;
    logic root_last;
    logic out_free;
  } sgm_sts_t;

endpackage

### src/sobel_gradient_magnitude_core.sv
// Streaming 3x3 Sobel gradient magnitude core: top level joining the
// controller and the datapath. Depends on sgm_pkg, sgm_ctrl and sgm_datapath.
//
// Pixels enter in raster order, one item at a time. A border pixel passes
// through the idle and read states only; an interior pixel also passes through
// both squaring states, the square root unit that yields one result bit per cycle
// and any wait for the output register. The single multiplier squares gx and gy in turn.
// A result for pixel (r-1, c-1) leaves when pixel (r, c) has entered, and it
// waits in an output register so the next pixel can enter meanwhile. Writing
// either frame register restarts the frame; write only while the core is idle.
module sobel_gradient_magnitude_core #(
  parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sgm_pkg::PIX_W-1:0]       in_tdata,   // [7:0] pixel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sgm_pkg::OUT_DATA_W-1:0]  out_tdata,  // magnitude, out_row, out_col, zero pad
  output logic                            out_tlast,  // frame_last
  input  logic                            cfg_wr_en,
  input  logic [sgm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sgm_pkg::CFG_W-1:0]       cfg_data
);
  import sgm_pkg::*;

  localparam int PAD_W = OUT_DATA_W - MAG_W - ROW_W - COL_W;

  sgm_cmd_t         cmd;
  sgm_sts_t         sts;
  logic [MAG_W-1:0] magnitude;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;

  sgm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sgm_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .pixel      (in_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .magnitude  (magnitude),
    .out_row    (out_row),
    .out_col    (out_col),
    .frame_last (out_tlast)
  );

  assign out_tdata = {{PAD_W{1'b0}}, out_col, out_row, magnitude};

endmodule

### src/sgm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the two line stores of the Sobel core.
module sgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/sgm_ctrl.sv
// Controller state machine of the Sobel core: sequences read, gradient,
// squaring, square root and result hand-off. Depends on sgm_pkg.
module sgm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sgm_pkg::sgm_sts_t sts,
  output sgm_pkg::sgm_cmd_t cmd
);
  import sgm_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_SQX  = 6'b000100,
    ST_SQY  = 6'b001000,
    ST_ROOT = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = sts.interior ? ST_SQX : ST_IDLE;
      end
      ST_SQX:  state_nxt = ST_SQY;
      ST_SQY:  state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (sts.root_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready    = (state_r == ST_IDLE);
  assign cmd.rd       = (state_r == ST_IDLE) && in_tvalid;
  assign cmd.step     = (state_r == ST_READ);
  assign cmd.sq_x     = (state_r == ST_SQX);
  assign cmd.sq_y     = (state_r == ST_SQY);
  assign cmd.root     = (state_r == ST_ROOT);
  assign cmd.load_out = (state_r == ST_DONE) && sts.out_free;

endmodule

### src/sgm_datapath.sv
// Datapath of the Sobel core: frame registers, counters, line stores, window,
// gradient sums, shared squarer, square root unit and output register.
// Depends on sgm_pkg and sgm_ram.
module sgm_datapath #(
  parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [sgm_pkg::PIX_W-1:0]      pixel,
  input  logic                           cfg_wr_en,
  input  logic [sgm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgm_pkg::CFG_W-1:0]      cfg_data,
  input  sgm_pkg::sgm_cmd_t              cmd,
  output sgm_pkg::sgm_sts_t              sts,
  input  logic                           out_tready,
  output logic                           out_tvalid,
  output logic [sgm_pkg::MAG_W-1:0]      magnitude,
  output logic [sgm_pkg::ROW_W-1:0]      out_row,
  output logic [sgm_pkg::COL_W-1:0]      out_col,
  output logic                           frame_last
);
  import sgm_pkg::*;

  localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HW        = $clog2(MAX_HEIGHT);
  localparam int WIDTH_RST = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int ROOT_TOP  = SUM_W - 1;

  logic [AW-1:0]   width_m1_r, width_m1_nxt;
  logic [HW-1:0]   height_m1_r, height_m1_nxt;
  logic [AW-1:0]   col_r;
  logic [HW-1:0]   row_r;
  logic [PIX_W-1:0] pixel_r;
  logic [PIX_W-1:0] top, mid;
  logic [PIX_W-1:0] win_r [6];
  logic signed [GRAD_W-1:0] gx_r, gy_r;
  logic signed [GRAD_W+1:0] gx_nxt, gy_nxt;
  logic signed [GRAD_W-1:0] mul_in;
  logic signed [2*GRAD_W-1:0] prod;
  logic [SUM_W-1:0] rem_r, res_r, bit_r;
  logic [SUM_W:0]   trial;
  logic [ROW_W-1:0] meta_row_r;
  logic [COL_W-1:0] meta_col_r;
  logic             meta_last_r;
  logic             out_tvalid_r;
  logic [MAG_W-1:0] magnitude_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic             frame_last_r;

  always_comb begin
    if (cfg_data < CFG_W'(3)) begin
      width_m1_nxt = AW'(2);
    end else if (int'(cfg_data) > MAX_WIDTH) begin
      width_m1_nxt = AW'(MAX_WIDTH - 1);
    end else begin
      width_m1_nxt = AW'(cfg_data - CFG_W'(1));
    end
    if (cfg_data < CFG_W'(3)) begin
      height_m1_nxt = HW'(2);
    end else if (int'(cfg_data) > MAX_HEIGHT) begin
      height_m1_nxt = HW'(MAX_HEIGHT - 1);
    end else begin
      height_m1_nxt = HW'(cfg_data - CFG_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_m1_r  <= AW'(WIDTH_RST - 1);
      height_m1_r <= HW'(RESET_HEIGHT - 1);
      col_r       <= '0;
      row_r       <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  width_m1_r  <= width_m1_nxt;
        REG_FRAME_HEIGHT: height_m1_r <= height_m1_nxt;
        default: ;
      endcase
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.step) begin
      if (col_r == width_m1_r) begin
        col_r <= '0;
        row_r <= (row_r == height_m1_r) ? '0 : row_r + HW'(1);
      end else begin
        col_r <= col_r + AW'(1);
      end
    end
  end

  // Rows 0 and 1 of every frame write each column before a read of it can
  // reach a result, so the line stores need no clearing after reset.
  sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (cmd.step),
    .waddr (col_r),
    .wdata (mid),
    .re    (cmd.rd),
    .raddr (col_r),
    .rdata (top)
  );

  sgm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (cmd.step),
    .waddr (col_r),
    .wdata (pixel_r),
    .re    (cmd.rd),
    .raddr (col_r),
    .rdata (mid)
  );

  always_comb begin
    gx_nxt = ($signed({5'b0, top}) - $signed({5'b0, win_r[0]}))
           + 13'sd2 * ($signed({5'b0, mid}) - $signed({5'b0, win_r[1]}))
           + ($signed({5'b0, pixel_r}) - $signed({5'b0, win_r[2]}));
    gy_nxt = ($signed({5'b0, win_r[0]}) + 13'sd2 * $signed({5'b0, win_r[3]})
              + $signed({5'b0, top}))
           - ($signed({5'b0, win_r[2]}) + 13'sd2 * $signed({5'b0, win_r[5]})
              + $signed({5'b0, pixel_r}));
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      pixel_r <= pixel;
    end
    if (cmd.step) begin
      win_r[0]    <= win_r[3];
      win_r[1]    <= win_r[4];
      win_r[2]    <= win_r[5];
      win_r[3]    <= top;
      win_r[4]    <= mid;
      win_r[5]    <= pixel_r;
      gx_r        <= GRAD_W'(gx_nxt);
      gy_r        <= GRAD_W'(gy_nxt);
      meta_row_r  <= ROW_W'(row_r - HW'(1));
      meta_col_r  <= COL_W'(col_r - AW'(1));
      meta_last_r <= (row_r == height_m1_r) && (col_r == width_m1_r);
    end
  end

  assign mul_in = cmd.sq_x ? gx_r : gy_r;
  assign prod   = mul_in * mul_in;
  assign trial  = {1'b0, res_r} + {1'b0, bit_r};

  always_ff @(posedge clk) begin
    if (cmd.sq_x) begin
      rem_r <= SUM_W'(prod);
    end else if (cmd.sq_y) begin
      rem_r <= rem_r + SUM_W'(prod);
      res_r <= '0;
      bit_r <= SUM_W'(1) << ROOT_TOP;
    end else if (cmd.root) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_r <= SUM_W'({1'b0, rem_r} - trial);
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      magnitude_r  <= MAG_W'(res_r);
      out_row_r    <= meta_row_r;
      out_col_r    <= meta_col_r;
      frame_last_r <= meta_last_r;
    end
  end

  assign sts.interior  = (row_r >= HW'(2)) && (col_r >= AW'(2));
  assign sts.root_last = bit_r[0];
  assign sts.out_free  = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign magnitude  = magnitude_r;
  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign frame_last = frame_last_r;

endmodule

### src/sgm_checker.sv
// Port-level checker of the Sobel gradient magnitude core, bound to the top.
// Depends on sobel_gradient_magnitude_core_macros.svh.
`include "sobel_gradient_magnitude_core_macros.svh"

module sgm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  `SGM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))
  `SGM_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready)
  `SGM_ASSERT_NOW(a_mag_range, out_tvalid, out_tdata[10:0] <= 11'd1442)
  `SGM_ASSERT_NOW(a_interior, out_tvalid, (out_tdata[22:11] != 12'd0) && (out_tdata[34:23] != 12'd0))

endmodule

bind sobel_gradient_magnitude_core sgm_checker u_sgm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

### dv/testbench.sv
// Self-checking testbench for the streaming Sobel gradient magnitude core.
// Holds its own line-buffer predictor in a small scoreboard class and drives
// pixels, frame registers and result backpressure. Depends on sgm_pkg and sobel_gradient_magnitude_core.
module testbench;
  import sgm_pkg::*;

  localparam int LINE_DEPTH    = MAX_WIDTH_DEF;
  localparam int LINE_AW       = $clog2(LINE_DEPTH);
  localparam int IDLE_LIMIT    = 20000;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_ITEMS  = 1950;

  typedef enum int {PIX_RANDOM, PIX_BINARY, PIX_FLAT} pix_mode_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_pattern_t;

  typedef struct {
    logic [MAG_W-1:0] magnitude;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } gradient_result_t;

  class gradient_predictor;
    logic [PIX_W-1:0] upper_line [LINE_DEPTH];
    logic [PIX_W-1:0] middle_line [LINE_DEPTH];
    logic [PIX_W-1:0] window [6];
    int unsigned      row_cnt;
    int unsigned      col_cnt;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    gradient_result_t magnitudes_due [$];
    int               errors;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      row_cnt    = 0;
      col_cnt    = 0;
      width_reg  = CFG_W'(RESET_WIDTH);
      height_reg = CFG_W'(RESET_HEIGHT);
      errors     = 0;
    endfunction

    static function int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
      int unsigned u;
      u = 32'(v);
      if (u < 3) return 3;
      if (u > hi) return hi;
      return u;
    endfunction

    static function logic [MAG_W-1:0] floor_root(int unsigned v);
      logic [MAG_W-1:0] res;
      logic [MAG_W-1:0] trial;
      int unsigned      tsq;
      res = '0;
      for (int b = MAG_W - 1; b >= 0; b--) begin
        trial = res | (MAG_W'(1) << b);
        tsq   = 32'(trial) * 32'(trial);
        if (tsq <= v) res = trial;
      end
      return res;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_FRAME_WIDTH:  width_reg  = v;
        REG_FRAME_HEIGHT: height_reg = v;
        default: ;
      endcase
      row_cnt = 0;
      col_cnt = 0;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix);
      int unsigned      w, h, r, c;
      int               top, mid, bot, lt, lm, lb, ct, cb, gx, gy;
      logic [LINE_AW-1:0] ci;
      gradient_result_t res;
      w = clamp_dim(width_reg, MAX_WIDTH_DEF);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
      end
      if (row_cnt >= h) row_cnt = 0;
      r = row_cnt;
      c = col_cnt;
      ci = LINE_AW'(c);
      top = int'(upper_line[ci]);
      mid = int'(middle_line[ci]);
      bot = int'(pix);
      upper_line[ci]  = mid[PIX_W-1:0];
      middle_line[ci] = pix;
      if (r >= 2 && c >= 2) begin
        lt = int'(window[0]);
        lm = int'(window[1]);
        lb = int'(window[2]);
        ct = int'(window[3]);
        cb = int'(window[5]);
        gx = (top - lt) + 2 * (mid - lm) + (bot - lb);
        gy = (lt + 2 * ct + top) - (lb + 2 * cb + bot);
        res.magnitude = floor_root($unsigned(gx * gx + gy * gy));
        res.row       = ROW_W'(r - 1);
        res.col       = COL_W'(c - 1);
        res.last      = (r == h - 1) && (c == w - 1);
        magnitudes_due.push_back(res);
      end
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = top[PIX_W-1:0];
      window[4] = mid[PIX_W-1:0];
      window[5] = pix;
      col_cnt = c + 1;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt = r + 1;
        if (row_cnt >= h) row_cnt = 0;
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data, logic last);
      gradient_result_t want;
      logic [MAG_W-1:0] got_mag;
      logic [ROW_W-1:0] got_row;
      logic [COL_W-1:0] got_col;
      got_mag = data[MAG_W-1:0];
      got_row = data[MAG_W +: ROW_W];
      got_col = data[MAG_W + ROW_W +: COL_W];
      if (magnitudes_due.size() == 0) begin
        report_mismatch($sformatf("result with none pending, data %h", data));
      end else begin
        want = magnitudes_due.pop_front();
        if (got_mag !== want.magnitude)
          report_mismatch($sformatf("magnitude at (%0d,%0d): got %0d want %0d",
                                    want.row, want.col, got_mag, want.magnitude));
        if (got_row !== want.row)
          report_mismatch($sformatf("row: got %0d want %0d", got_row, want.row));
        if (got_col !== want.col)
          report_mismatch($sformatf("col: got %0d want %0d", got_col, want.col));
        if (last !== want.last)
          report_mismatch($sformatf("frame end at (%0d,%0d): got %b want %b",
                                    want.row, want.col, last, want.last));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  gradient_predictor predictor;
  logic [CFG_W-1:0]  width_set = CFG_W'(RESET_WIDTH);
  logic [CFG_W-1:0]  height_set = CFG_W'(RESET_HEIGHT);
  int                burst_left = 0;
  int                items_sent = 0;
  int                flat_base = 0;
  int                idle_cycles = 0;
  int unsigned       rx_cycle = 0;
  rx_pattern_t       rx_mode = RX_OPEN;

  sobel_gradient_magnitude_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) predictor.write_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (out_tvalid && out_tready) predictor.check_result(out_tdata, out_tlast);
      if (in_tvalid && in_tready) predictor.note_pixel(in_tdata);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("[sobel_gradient_magnitude_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle[7:0] == 8'd0) rx_mode <= rx_pattern_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= ($urandom_range(0, 5) == 0);
      default:   out_tready <= (rx_cycle[4:0] < 5'd6);
    endcase
  end

  function automatic logic [PIX_W-1:0] make_pixel(pix_mode_t mode);
    int v;
    case (mode)
      PIX_BINARY: v = $urandom_range(0, 1) ? 255 : 0;
      PIX_FLAT:   v = flat_base + int'($urandom_range(0, 6)) - 3;
      default:    v = $urandom_range(0, 255);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return PIX_W'(v);
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  task automatic send_run(input int count, input pix_mode_t mode);
    flat_base = $urandom_range(0, 255);
    for (int i = 0; i < count; i++) send_pixel(make_pixel(mode));
    items_sent += count;
  endtask

  // The core must be idle before a register write, so drain all results first.
  task automatic set_frame(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv,
                           input bit wr_w, input bit wr_h);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (predictor.magnitudes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (wr_w) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_FRAME_WIDTH;
      cfg_data  <= wv;
      width_set = wv;
      @(posedge clk);
    end
    if (wr_h) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_FRAME_HEIGHT;
      cfg_data  <= hv;
      height_set = hv;
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int               eff_w, eff_h, n_frames, choice, sel;
    logic [CFG_W-1:0] wv, hv;
    bit               wr_w, wr_h;
    pix_mode_t        mode;
    predictor = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_run(5, PIX_RANDOM);

    // Smallest frame, reached through clamped values: a vertical then a horizontal edge.
    set_frame(13'd0, 13'd2, 1'b1, 1'b1);
    for (int i = 0; i < 9; i++) send_pixel((i % 3 == 2) ? 8'd255 : 8'd0);
    for (int i = 0; i < 9; i++) send_pixel((i < 3) ? 8'd255 : ((i < 6) ? 8'd128 : 8'd0));

    // Widest rows: a short run that stays within the first row.
    set_frame(13'd4096, 13'd3, 1'b1, 1'b1);
    send_run(40, PIX_RANDOM);
    set_frame(13'h1FFF, 13'h1FFF, 1'b1, 1'b1);
    send_run(20, PIX_BINARY);
    set_frame(13'd3, 13'd4097, 1'b1, 1'b1);
    send_run(18, PIX_RANDOM);

    while (items_sent < RANDOM_ITEMS) begin
      choice = $urandom_range(0, 9);
      if (choice == 0) wv = CFG_W'($urandom_range(0, 2));
      else if (choice < 8) wv = CFG_W'($urandom_range(3, 10));
      else wv = CFG_W'($urandom_range(11, 40));
      hv = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(0, 2))
                                       : CFG_W'($urandom_range(3, 6));
      sel  = $urandom_range(0, 9);
      wr_w = (sel != 1);
      wr_h = (sel != 0);
      if (gradient_predictor::clamp_dim(width_set, MAX_WIDTH_DEF) > 40) wr_w = 1'b1;
      if (gradient_predictor::clamp_dim(height_set, MAX_HEIGHT) > 6) wr_h = 1'b1;
      set_frame(wv, hv, wr_w, wr_h);
      eff_w = gradient_predictor::clamp_dim(width_set, MAX_WIDTH_DEF);
      eff_h = gradient_predictor::clamp_dim(height_set, MAX_HEIGHT);
      n_frames = $urandom_range(1, 3);
      for (int f = 0; f < n_frames; f++) begin
        mode = pix_mode_t'($urandom_range(0, 2));
        if ($urandom_range(0, 9) == 0) begin
          send_run($urandom_range(1, eff_w * eff_h - 1), mode);
          break;
        end
        send_run(eff_w * eff_h, mode);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (predictor.magnitudes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (predictor.errors == 0) begin
      $display("[sobel_gradient_magnitude_core] OK");
    end else begin
      $display("[sobel_gradient_magnitude_core] ERROR");
    end
    $finish;
  end
endmodule
